// ----- src/normalized_wall_energy_density_core_defines.svh -----
// assertion helpers
`ifndef NORMALIZED_WALL_ENERGY_DENSITY_CORE_DEFINES_SVH
`define NORMALIZED_WALL_ENERGY_DENSITY_CORE_DEFINES_SVH

// same-cycle implication
`define NWED_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NWED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/nwed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nwed_pkg;
	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_NORMAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CROSS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SHEAR_SYM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SHEAR_ANTI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SCALE    = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] pol_x;
		logic signed [DATA_W-1:0] pol_y;
		logic signed [DATA_W-1:0] pol_z;
		logic signed [DATA_W-1:0] dpx_dx;
		logic signed [DATA_W-1:0] dpx_dy;
		logic signed [DATA_W-1:0] dpx_dz;
		logic signed [DATA_W-1:0] dpy_dx;
		logic signed [DATA_W-1:0] dpy_dy;
		logic signed [DATA_W-1:0] dpy_dz;
		logic signed [DATA_W-1:0] dpz_dx;
		logic signed [DATA_W-1:0] dpz_dy;
		logic signed [DATA_W-1:0] dpz_dz;
	} point_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] energy;
		logic                     zero_magnitude;
		logic                     saturated;
	} result_t;
endpackage
`default_nettype wire

// ----- src/normalized_wall_energy_density_core.sv -----
// Throughput: one item per cycle; each stage advances when the next one frees up.
// Magnitude square root runs 2 bits per stage over 16 stages; the divider, 2 bits per
// stage over 16 stages; these set the depth.
// Reset: asynchronous, clears valid bits and loads register reset values.
`timescale 1ns / 1ps
`default_nettype none
module normalized_wall_energy_density_core #(
	parameter int FRAC_BITS = nwed_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              point_valid,
	output logic                             point_stall,
	input  nwed_pkg::point_t                 point,
	output logic                             result_valid,
	input  wire                              result_stall,
	output nwed_pkg::result_t                result,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [nwed_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [nwed_pkg::DATA_W-1:0]       cfg_data
);
	import nwed_pkg::*;

	localparam int SW  = 67;
	localparam int TW  = 100;
	localparam int EW  = TW - 2 * FRAC_BITS - 1;
	localparam int HW  = EW - 34;
	localparam int ELW = EW + 32;
	localparam int NS  = 37;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [31:0] rem;
		logic        qb;
	} dv_t;

	function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
		logic [34:0] rs;
		logic [34:0] trial;
		sq_t         nx;
		rs    = {cur.rem[32:0], pair};
		trial = {1'b0, cur.root, 2'b01};
		if (rs >= trial) begin
			nx.rem  = rs - trial;
			nx.root = {cur.root[30:0], 1'b1};
		end else begin
			nx.rem  = rs;
			nx.root = {cur.root[30:0], 1'b0};
		end
		return nx;
	endfunction

	function automatic dv_t dv_step(input logic [31:0] rem, input logic nb,
			input logic [31:0] m);
		logic [32:0] r2;
		dv_t         nx;
		r2 = {rem, nb};
		if (r2 >= {1'b0, m}) begin
			nx.rem = 32'(r2 - {1'b0, m});
			nx.qb  = 1'b1;
		end else begin
			nx.rem = r2[31:0];
			nx.qb  = 1'b0;
		end
		return nx;
	endfunction

	logic signed [DATA_W-1:0] coef_q [0:3];
	logic signed [DATA_W-1:0] len_q;

	logic [1:NS] vld_s;
	logic [1:NS] en;

	point_t                   pt_s1;
	logic signed [31:0]       diag_s2 [0:2];
	logic signed [32:0]       ssum_s2 [0:2];
	logic signed [32:0]       sdif_s2 [0:2];
	logic signed [63:0]       psq_s2  [0:2];
	logic signed [63:0]       nn_s3   [0:2];
	logic signed [63:0]       cr_s3   [0:2];
	logic signed [65:0]       ss_s3   [0:2];
	logic signed [65:0]       sa_s3   [0:2];
	logic [63:0]              pss_s3;
	logic signed [SW-1:0]     grp_s4  [0:3];
	logic signed [66:0]       pl_s5   [0:3];
	logic signed [64:0]       ph_s5   [0:3];
	logic signed [68:0]       tlo_s6;
	logic signed [66:0]       thi_s6;
	logic signed [EW-1:0]     e_s7;
	logic signed [66:0]       ell_s8;
	logic signed [HW+31:0]    elh_s8;
	logic signed [ELW-1:0]    el_s9;
	logic [ELW-1:0]           mag_s   [10:19];
	logic                     neg_s   [10:36];
	logic [63:0]              sq_x_s  [4:19];
	sq_t                      sq_s    [4:19];
	logic                     big_s   [20:36];
	logic [31:0]              m_s     [20:36];
	logic [31:0]              dv_rem_s[20:36];
	logic [31:0]              dv_q_s  [20:36];
	result_t                  res_s37;

	logic signed [TW-1:0]     t_full;
	logic signed [ELW-1:0]    el_full;
	sq_t                      sq_nx   [4:19];
	logic [63:0]              sq_xnx  [4:19];
	dv_t                      dv_a    [21:36];
	dv_t                      dv_b    [21:36];
	logic [31:0]              lim;
	logic                     sat;
	logic [31:0]              qval;
	result_t                  res_nx;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				coef_q[i] <= '0;
			end
			len_q <= DATA_W'(1) <<< FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_NORMAL:     coef_q[0] <= cfg_data;
				REG_COEF_CROSS:      coef_q[1] <= cfg_data;
				REG_COEF_SHEAR_SYM:  coef_q[2] <= cfg_data;
				REG_COEF_SHEAR_ANTI: coef_q[3] <= cfg_data;
				REG_LENGTH_SCALE:    len_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	always_comb begin
		en[NS] = !vld_s[NS] || !result_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign point_stall  = !en[1];
	assign result_valid = vld_s[NS];
	assign result       = res_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= point_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// wide combines and iterative steps
	always_comb begin
		t_full  = (TW'(thi_s6) <<< 34) + TW'(tlo_s6);
		el_full = (ELW'(elh_s8) <<< 34) + ELW'(ell_s8);

		sq_nx[4]  = sq_step(sq_step('0, pss_s3[63:62]), pss_s3[61:60]);
		sq_xnx[4] = pss_s3 << 4;
		for (int k = 5; k <= 19; k++) begin
			sq_nx[k]  = sq_step(sq_step(sq_s[k-1], sq_x_s[k-1][63:62]), sq_x_s[k-1][61:60]);
			sq_xnx[k] = sq_x_s[k-1] << 4;
		end

		for (int k = 21; k <= 36; k++) begin
			dv_a[k] = dv_step(dv_rem_s[k-1], dv_q_s[k-1][31], m_s[k-1]);
			dv_b[k] = dv_step(dv_a[k].rem, dv_q_s[k-1][30], m_s[k-1]);
		end

		lim    = neg_s[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sat    = big_s[36] || (dv_q_s[36] > lim);
		qval   = sat ? lim : dv_q_s[36];
		res_nx.energy         = neg_s[36] ? -qval : qval;
		res_nx.zero_magnitude = 1'b0;
		res_nx.saturated      = sat;
		if (m_s[36] == '0) begin
			res_nx.energy         = '0;
			res_nx.zero_magnitude = 1'b1;
			res_nx.saturated      = 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pt_s1 <= point;
		end
		if (en[2]) begin
			diag_s2[0] <= pt_s1.dpx_dx;
			diag_s2[1] <= pt_s1.dpy_dy;
			diag_s2[2] <= pt_s1.dpz_dz;
			ssum_s2[0] <= {pt_s1.dpx_dy[31], pt_s1.dpx_dy} + {pt_s1.dpy_dx[31], pt_s1.dpy_dx};
			ssum_s2[1] <= {pt_s1.dpy_dz[31], pt_s1.dpy_dz} + {pt_s1.dpz_dy[31], pt_s1.dpz_dy};
			ssum_s2[2] <= {pt_s1.dpx_dz[31], pt_s1.dpx_dz} + {pt_s1.dpz_dx[31], pt_s1.dpz_dx};
			sdif_s2[0] <= {pt_s1.dpx_dy[31], pt_s1.dpx_dy} - {pt_s1.dpy_dx[31], pt_s1.dpy_dx};
			sdif_s2[1] <= {pt_s1.dpy_dz[31], pt_s1.dpy_dz} - {pt_s1.dpz_dy[31], pt_s1.dpz_dy};
			sdif_s2[2] <= {pt_s1.dpx_dz[31], pt_s1.dpx_dz} - {pt_s1.dpz_dx[31], pt_s1.dpz_dx};
			psq_s2[0]  <= pt_s1.pol_x * pt_s1.pol_x;
			psq_s2[1]  <= pt_s1.pol_y * pt_s1.pol_y;
			psq_s2[2]  <= pt_s1.pol_z * pt_s1.pol_z;
		end
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				nn_s3[i] <= diag_s2[i] * diag_s2[i];
				ss_s3[i] <= ssum_s2[i] * ssum_s2[i];
				sa_s3[i] <= sdif_s2[i] * sdif_s2[i];
			end
			cr_s3[0] <= diag_s2[0] * diag_s2[1];
			cr_s3[1] <= diag_s2[1] * diag_s2[2];
			cr_s3[2] <= diag_s2[0] * diag_s2[2];
			pss_s3   <= $unsigned(psq_s2[0]) + $unsigned(psq_s2[1]) + $unsigned(psq_s2[2]);
		end
		if (en[4]) begin
			grp_s4[0] <= nn_s3[0] + nn_s3[1] + nn_s3[2];
			grp_s4[1] <= (cr_s3[0] + cr_s3[1] + cr_s3[2]) <<< 1;
			grp_s4[2] <= ss_s3[0] + ss_s3[1] + ss_s3[2];
			grp_s4[3] <= sa_s3[0] + sa_s3[1] + sa_s3[2];
		end
		if (en[5]) begin
			for (int i = 0; i < 4; i++) begin
				pl_s5[i] <= coef_q[i] * $signed({1'b0, grp_s4[i][33:0]});
				ph_s5[i] <= coef_q[i] * $signed(grp_s4[i][SW-1:34]);
			end
		end
		if (en[6]) begin
			tlo_s6 <= pl_s5[0] + pl_s5[1] + pl_s5[2] + pl_s5[3];
			thi_s6 <= ph_s5[0] + ph_s5[1] + ph_s5[2] + ph_s5[3];
		end
		if (en[7]) begin
			e_s7 <= t_full[TW-1:2*FRAC_BITS+1];
		end
		if (en[8]) begin
			ell_s8 <= len_q * $signed({1'b0, e_s7[33:0]});
			elh_s8 <= len_q * $signed(e_s7[EW-1:34]);
		end
		if (en[9]) begin
			el_s9 <= el_full;
		end
		if (en[10]) begin
			neg_s[10] <= el_s9[ELW-1];
			mag_s[10] <= el_s9[ELW-1] ? -el_s9 : el_s9;
		end
		for (int k = 11; k <= 19; k++) begin
			if (en[k]) begin
				mag_s[k] <= mag_s[k-1];
			end
		end
		for (int k = 11; k <= 36; k++) begin
			if (en[k]) begin
				neg_s[k] <= neg_s[k-1];
			end
		end
		for (int k = 4; k <= 19; k++) begin
			if (en[k]) begin
				sq_s[k]   <= sq_nx[k];
				sq_x_s[k] <= sq_xnx[k];
			end
		end
		if (en[20]) begin
			big_s[20]    <= mag_s[19][ELW-1:32] >= (ELW-32)'(sq_s[19].root);
			m_s[20]      <= sq_s[19].root;
			dv_rem_s[20] <= mag_s[19][63:32];
			dv_q_s[20]   <= mag_s[19][31:0];
		end
		for (int k = 21; k <= 36; k++) begin
			if (en[k]) begin
				big_s[k]    <= big_s[k-1];
				m_s[k]      <= m_s[k-1];
				dv_rem_s[k] <= dv_b[k].rem;
				dv_q_s[k]   <= {dv_q_s[k-1][29:0], dv_a[k].qb, dv_b[k].qb};
			end
		end
		if (en[NS]) begin
			res_s37 <= res_nx;
		end
	end
endmodule
`default_nettype wire

// ----- src/nwed_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "normalized_wall_energy_density_core_defines.svh"
module nwed_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               result_valid,
	input wire               result_stall,
	input nwed_pkg::result_t result
);
	import nwed_pkg::*;

	`NWED_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled item changed")
	`NWED_ASSERT(a_zero, result_valid && result.zero_magnitude, result.energy == 0 && !result.saturated, "zero magnitude item not cleared")
	`NWED_ASSERT(a_sat, result_valid && result.saturated, result.energy == 32'sh7FFF_FFFF || result.energy == 32'sh8000_0000, "saturated item not at a limit")
endmodule

bind normalized_wall_energy_density_core nwed_chk u_nwed_chk (.*);
`default_nettype wire

// ----- verif/normalized_wall_energy_density_core_tb.sv -----
`timescale 1ns / 1ps
module normalized_wall_energy_density_core_tb;
	import nwed_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = 37;
	localparam int LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int N_REGS = 5;

	typedef struct {
		point_t  p;
		bit      known;
		result_t want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic point_valid = 0;
	logic point_stall;
	point_t point = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	logic signed [31:0] coef[N_REGS];
	result_t energy_due[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	row_t rows[$];

	normalized_wall_energy_density_core uut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("** normalized_wall_energy_density_core: FAILED **");
			$finish;
		end
	end

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [127:0] mul(logic signed [32:0] a, logic signed [32:0] b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	function automatic result_t energy_of(point_t p);
		logic signed [127:0] sn, sc, ss, sa, t, e, g11, g12, g44, g44p, ls;
		logic signed [63:0] px, py, pz;
		logic [63:0] m;
		logic [127:0] mag, q, lim;
		logic neg;
		result_t r;
		px = p.pol_x;
		py = p.pol_y;
		pz = p.pol_z;
		m = isqrt(64'(px * px) + 64'(py * py) + 64'(pz * pz));
		r = '0;
		if (m == 0) begin
			r.zero_magnitude = 1;
			return r;
		end
		sn = mul(p.dpx_dx, p.dpx_dx) + mul(p.dpy_dy, p.dpy_dy) + mul(p.dpz_dz, p.dpz_dz);
		sc = mul(p.dpx_dx, p.dpy_dy) + mul(p.dpy_dy, p.dpz_dz) + mul(p.dpx_dx, p.dpz_dz);
		ss = mul(33'(p.dpx_dy) + 33'(p.dpy_dx), 33'(p.dpx_dy) + 33'(p.dpy_dx))
			+ mul(33'(p.dpy_dz) + 33'(p.dpz_dy), 33'(p.dpy_dz) + 33'(p.dpz_dy))
			+ mul(33'(p.dpx_dz) + 33'(p.dpz_dx), 33'(p.dpx_dz) + 33'(p.dpz_dx));
		sa = mul(33'(p.dpx_dy) - 33'(p.dpy_dx), 33'(p.dpx_dy) - 33'(p.dpy_dx))
			+ mul(33'(p.dpy_dz) - 33'(p.dpz_dy), 33'(p.dpy_dz) - 33'(p.dpz_dy))
			+ mul(33'(p.dpx_dz) - 33'(p.dpz_dx), 33'(p.dpx_dz) - 33'(p.dpz_dx));
		g11 = coef[REG_COEF_NORMAL];
		g12 = coef[REG_COEF_CROSS];
		g44 = coef[REG_COEF_SHEAR_SYM];
		g44p = coef[REG_COEF_SHEAR_ANTI];
		ls = coef[REG_LENGTH_SCALE];
		t = sn * g11 + (sc <<< 1) * g12 + ss * g44 + sa * g44p;
		e = (t >>> (2 * FRAC + 1)) * ls;
		neg = e[127];
		mag = neg ? -e : e;
		q = mag / {64'd0, m};
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) begin
			q = lim;
			r.saturated = 1;
		end
		r.energy = neg ? -q[31:0] : q[31:0];
		return r;
	endfunction

	always @(negedge clk)
		result_stall <= !calm && ($urandom_range(99) < 29);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (energy_due.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = energy_due.pop_front();
				if (result.energy !== want.energy) begin
					$error("energy: expected %h, got %h", want.energy, result.energy);
					errors++;
				end
				if (result.zero_magnitude !== want.zero_magnitude) begin
					$error("zero_magnitude: expected %b, got %b",
						want.zero_magnitude, result.zero_magnitude);
					errors++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated: expected %b, got %b", want.saturated, result.saturated);
					errors++;
				end
			end
		end
	end

	task automatic send_point(point_t p, bit known, result_t want);
		if (!calm && $urandom_range(99) < 29) begin
			point_valid = 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		point = p;
		point_valid = 1;
		do @(posedge clk); while (point_stall);
		energy_due.push_back(known ? want : energy_of(p));
		@(negedge clk);
	endtask

	task automatic drain();
		point_valid = 0;
		while (energy_due.size() != 0) @(negedge clk);
		repeat (LATENCY + 3) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		if (idx < N_REGS) coef[idx] = val;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic cfg_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d, logic [31:0] l);
		cfg_write(REG_COEF_NORMAL, a);
		cfg_write(REG_COEF_CROSS, b);
		cfg_write(REG_COEF_SHEAR_SYM, c);
		cfg_write(REG_COEF_SHEAR_ANTI, d);
		cfg_write(REG_LENGTH_SCALE, l);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: case ($urandom_range(4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0;
				3: return 32'h1;
				default: return 32'hffff_ffff;
			endcase
			1, 2: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			default: return $urandom();
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
		if ($urandom_range(15) == 0) begin
			p.pol_x = 0;
			p.pol_y = 0;
			p.pol_z = 0;
		end
		return p;
	endfunction

	function automatic point_t uniform(logic [31:0] pv, logic [31:0] dv);
		return {pv, pv, pv, dv, dv, dv, dv, dv, dv, dv, dv, dv};
	endfunction

	function automatic row_t row(point_t p, bit known, logic zm);
		row_t r;
		r.p = p;
		r.known = known;
		r.want = '0;
		r.want.zero_magnitude = zm;
		return r;
	endfunction

	initial begin
		point_t p;
		coef[REG_COEF_NORMAL] = 0;
		coef[REG_COEF_CROSS] = 0;
		coef[REG_COEF_SHEAR_SYM] = 0;
		coef[REG_COEF_SHEAR_ANTI] = 0;
		coef[REG_LENGTH_SCALE] = 32'h0001_0000;

		// all-zero coefficients after reset: energy is 0 for any point
		rows.push_back(row(uniform(32'h0, 32'h7fff_ffff), 1, 1));
		rows.push_back(row(uniform(32'h0, 32'h8000_0000), 1, 1));
		rows.push_back(row(uniform(32'h8000_0000, 32'h8000_0000), 1, 0));
		rows.push_back(row(uniform(32'h7fff_ffff, 32'h7fff_ffff), 1, 0));
		rows.push_back(row(uniform(32'h1, 32'h0), 1, 0));
		rows.push_back(row(uniform(32'hffff_ffff, 32'hffff_ffff), 1, 0));
		p = uniform(32'h0, 32'h0001_0000);
		p.pol_z = 32'h1;
		rows.push_back(row(p, 0, 0));
		p = uniform(32'h0001_0000, 32'h7fff_ffff);
		p.dpy_dx = 32'h8000_0000;
		p.dpz_dy = 32'h8000_0000;
		p.dpx_dz = 32'h8000_0000;
		rows.push_back(row(p, 0, 0));
		p = uniform(32'h0000_4000, 32'h0002_0000);
		p.dpy_dy = 32'hfffe_0000;
		p.pol_y = 32'hffff_0000;
		rows.push_back(row(p, 0, 0));
		p = uniform(32'h1, 32'h7fff_ffff);
		rows.push_back(row(p, 0, 0));
		p = uniform(32'h8000_0000, 32'h0);
		p.dpx_dy = 32'h0001_0000;
		rows.push_back(row(p, 0, 0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i]) send_point(rows[i].p, rows[i].known, rows[i].want);
		drain();

		cfg_write(REG_UNUSED, 32'hdead_beef);
		cfg_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		foreach (rows[i]) send_point(rows[i].p, 0, '0);
		drain();
		cfg_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		foreach (rows[i]) send_point(rows[i].p, 0, '0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: cfg_all(32'h0001_0000, 32'h0000_8000, 32'hffff_0000, 32'h0000_4000,
					32'h0001_0000);
				1: cfg_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				2: cfg_all(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
				3: cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
				default: cfg_all(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff,
					32'h0000_0001);
			endcase
			for (int n = 0; n < 230; n++) begin
				calm = (ph == 1 && n >= 40 && n < 140);
				if (ph == 2 && n == 115) begin
					point_valid = 0;
					while (energy_due.size() != 0) @(negedge clk);
				end
				send_point(rand_point(), 0, '0);
			end
			calm = 0;
			drain();
		end

		if (errors == 0) begin
			$display("** normalized_wall_energy_density_core: PASSED **");
		end else begin
			$display("** normalized_wall_energy_density_core: FAILED **");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/nwed_pkg.sv
src/normalized_wall_energy_density_core.sv
src/nwed_chk.sv
verif/normalized_wall_energy_density_core_tb.sv
